// File: hw/rtl/opte_pkg.sv
// Package for the onset peak picker and tempo estimator.
// Holds shared widths, reset values, register indexes and field types.
// No dependencies.
package opte_pkg;

    localparam int FLUX_W   = 16;
    localparam int DT_W     = 16;
    localparam int TEMPO_W  = 16;
    localparam int CONF_W   = 16;
    localparam int CFG_W    = 22;
    localparam int IDX_W    = 3;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 22;

    localparam int HISTORY_DEPTH_DEF = 16;

    localparam logic [15:0] ALPHA_RST   = 16'd6554;
    localparam logic [11:0] GAIN_RST    = 12'd384;
    localparam logic [19:0] MINP_RST    = 20'd300000;
    localparam logic [21:0] MAXP_RST    = 22'd1000000;
    localparam logic [19:0] UPDP_RST    = 20'd200000;

    localparam logic [IDX_W-1:0] REG_ALPHA = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_MINP  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAXP  = 3'd3;
    localparam logic [IDX_W-1:0] REG_UPDP  = 3'd4;

    // result fields, highest bit first in the stream word
    typedef struct packed {
        logic        detected;
        logic [15:0] confidence;
        logic [15:0] tempo_centi_bpm;
        logic        updated;
        logic        beat;
    } result_t;

endpackage

// File: hw/rtl/opte_ram.sv
// Generic single-port write, single read RAM with registered read data.
// No dependencies.
module opte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/onset_peak_tempo_estimator.sv
// Onset peak picker and tempo estimator, top level.
// Depends on opte_pkg and opte_ram.
//
// One input transaction carries one flux sample and its time step. Each input
// transaction returns exactly one result transaction. The block is sequential:
// s_tready is high only while the sequencer idles.
// A plain sample runs through the averaging, beat and update states before
// its result is offered. An update with fewer than four stored beats skips
// the estimate. A full estimate with N stored beats and m = N - 1 intervals
// runs in five parts: the serial history walk, the variance pass, the
// insertion sort over one RAM port, the 32-step square root, and three
// 64-step restoring divisions that share one subtract unit. A result stalled
// by m_tready holds the sequencer in its output state. Beat history is a ring
// in a RAM, and history entries are unwritten until a beat occurs. Write
// configuration only while the block is idle and no result is pending.
module onset_peak_tempo_estimator #(
    parameter int HISTORY_DEPTH = opte_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [opte_pkg::IDX_W-1:0] cfg_index,
    input  logic [opte_pkg::CFG_W-1:0] cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // flux[15:0], dt_us[31:16]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata    // beat, updated, tempo[15:0], conf[15:0], detected
);
    import opte_pkg::*;

    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_AVG1, S_AVG2, S_BEAT, S_UPD,
        S_IVRD, S_IVWAIT, S_IVGET, S_SUM,
        S_VRD, S_VWAIT, S_VACC,
        S_SQRT, S_DIV1, S_SORT_RD, S_SORT_WAIT, S_SORT_CMP,
        S_MED_RD, S_MED_WAIT, S_TEMPO, S_CONF, S_OUT
    } state_t;

    state_t state_reg;

    logic [15:0] alpha_reg;
    logic [11:0] gain_reg;
    logic [19:0] minp_reg;
    logic [21:0] maxp_reg;
    logic [19:0] updp_reg;

    logic [31:0] avg_reg;
    logic [31:0] now_reg;
    logic [21:0] tsb_reg;
    logic [20:0] utmr_reg;
    logic [CW-1:0] cnt_reg;
    logic [HW-1:0] head_reg;
    logic [15:0] tempo_reg;
    logic [15:0] conf_reg;
    logic        det_reg;

    logic [15:0] flux_reg;
    logic [15:0] dt_reg;
    logic        beat_reg;
    logic        upd_reg;
    logic [47:0] prod_reg;
    logic [47:0] acc_reg;

    // estimate workspace
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [31:0]   prev_reg;
    logic [31:0]   key_reg;
    logic [31:0]   s_reg;
    logic [63:0]   sq_reg;
    logic [63:0]   x_reg;
    logic [63:0]   r_reg;
    logic [63:0]   bit_reg;
    logic [63:0]   rem_reg;
    logic [63:0]   quo_reg;
    logic [63:0]   den_reg;
    logic [6:0]    k_reg;
    logic [1:0]    phase_reg;
    logic [15:0]   cval_reg;

    // history ring and interval scratch share one memory map: 2 * depth
    logic            ram_we;
    logic [HW:0]     ram_waddr;
    logic [HW:0]     ram_raddr;
    logic [31:0]     ram_wdata;
    logic [31:0]     ram_rdata;

    opte_ram #(.WIDTH(32), .DEPTH(2 * HISTORY_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [CW-1:0] m_cnt;
    assign m_cnt = cnt_reg - CW'(1);

    function automatic logic [HW-1:0] ring(input logic [HW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [HW:0] t;
        t = {1'b0, base} + (HW+1)'(off);
        if (t >= (HW+1)'(HISTORY_DEPTH))
        begin
            t = t - (HW+1)'(HISTORY_DEPTH);
        end
        return t[HW-1:0];
    endfunction

    function automatic logic [31:0] ivsat_d(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d > 32'd4194303) ? 32'd4194303 : d;
    endfunction

    logic [31:0] ivsat;
    assign ivsat = (ram_rdata > 32'd4194303) ? 32'd4194303 : ram_rdata;

    logic signed [63:0] dev;
    assign dev = $signed({32'd0, prod_reg[31:0]}) - $signed({32'd0, s_reg});

    logic [63:0] excess;
    logic [63:0] thr;
    assign excess = {24'd0, flux_reg, 24'd0} - {24'd0, avg_reg, 8'd0};
    assign thr    = {20'd0, prod_reg[43:0]};

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            alpha_reg <= ALPHA_RST;
            gain_reg  <= GAIN_RST;
            minp_reg  <= MINP_RST;
            maxp_reg  <= MAXP_RST;
            updp_reg  <= UPDP_RST;
            avg_reg   <= '0;
            now_reg   <= '0;
            tsb_reg   <= MAXP_RST;
            utmr_reg  <= '0;
            cnt_reg   <= '0;
            head_reg  <= '0;
            tempo_reg <= '0;
            conf_reg  <= '0;
            det_reg   <= 1'b0;
            m_tvalid  <= 1'b0;
            m_tdata   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALPHA: alpha_reg <= cfg_data[15:0];
                    REG_GAIN:  gain_reg  <= cfg_data[11:0];
                    REG_MINP:  minp_reg  <= cfg_data[19:0];
                    REG_MAXP:  maxp_reg  <= cfg_data[21:0];
                    REG_UPDP:  updp_reg  <= cfg_data[19:0];
                    default: ;
                endcase
            end
            // the output state reloads the register itself
            if (m_tvalid && m_tready && state_reg != S_OUT)
            begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        flux_reg  <= s_tdata[15:0];
                        dt_reg    <= s_tdata[31:16];
                        beat_reg  <= 1'b0;
                        upd_reg   <= 1'b0;
                        state_reg <= S_AVG1;
                    end
                end
                S_AVG1:
                begin
                    logic [22:0] tsum;
                    tsum = {1'b0, tsb_reg} + 23'(dt_reg);
                    now_reg  <= now_reg + 32'(dt_reg);
                    tsb_reg  <= (tsum > {1'b0, maxp_reg}) ? maxp_reg : tsum[21:0];
                    utmr_reg <= utmr_reg + 21'(dt_reg);
                    prod_reg <= 48'(17'h10000 - {1'b0, alpha_reg}) * 48'(avg_reg);
                    state_reg <= S_AVG2;
                end
                S_AVG2:
                begin
                    acc_reg  <= prod_reg + {32'(alpha_reg) * 32'(flux_reg), 16'd0};
                    state_reg <= S_BEAT;
                    prod_reg <= '0;
                end
                S_BEAT:
                begin
                    avg_reg  <= acc_reg[47:16];
                    prod_reg <= 48'(gain_reg) * 48'(acc_reg[47:16]);
                    state_reg <= S_UPD;
                    phase_reg <= 2'd0;
                end
                S_UPD:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        phase_reg <= 2'd1;
                        if ($signed(excess) > $signed(thr) && {2'b0, minp_reg} <= tsb_reg)
                        begin
                            beat_reg <= 1'b1;
                            tsb_reg  <= '0;
                            if (cnt_reg < CW'(HISTORY_DEPTH))
                            begin
                                cnt_reg <= cnt_reg + CW'(1);
                            end
                            else
                            begin
                                head_reg <= ring(head_reg, CW'(1));
                            end
                        end
                    end
                    else if (utmr_reg >= {1'b0, updp_reg})
                    begin
                        utmr_reg <= '0;
                        upd_reg  <= 1'b1;
                        if (cnt_reg < CW'(4))
                        begin
                            prod_reg <= 48'(conf_reg) * 48'd62259;
                            state_reg <= S_CONF;
                            phase_reg <= 2'd2;
                        end
                        else
                        begin
                            i_reg <= '0;
                            s_reg <= '0;
                            state_reg <= S_IVRD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                // walk history, store raw intervals at depth + i
                S_IVRD:
                begin
                    state_reg <= S_IVWAIT;
                end
                S_IVWAIT:
                begin
                    state_reg <= S_IVGET;
                end
                S_IVGET:
                begin
                    prev_reg <= ram_rdata;
                    if (i_reg != '0)
                    begin
                        s_reg <= s_reg + ivsat_d(ram_rdata, prev_reg);
                    end
                    if (i_reg == m_cnt)
                    begin
                        i_reg <= '0;
                        sq_reg <= '0;
                        state_reg <= S_VRD;
                    end
                    else
                    begin
                        i_reg <= i_reg + CW'(1);
                        state_reg <= S_IVRD;
                    end
                end
                S_VRD:
                begin
                    state_reg <= S_VWAIT;
                end
                S_VWAIT:
                begin
                    state_reg <= S_VACC;
                    phase_reg <= 2'd0;
                end
                S_VACC:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        prod_reg  <= 48'(ivsat) * 48'(m_cnt);
                        phase_reg <= 2'd1;
                    end
                    else if (phase_reg == 2'd1)
                    begin
                        x_reg <= dev[63] ? 64'(-dev) : 64'(dev);
                        phase_reg <= 2'd2;
                    end
                    else
                    begin
                        sq_reg <= sq_reg + x_reg[31:0] * x_reg[31:0];
                        if (i_reg + CW'(1) == m_cnt)
                        begin
                            // sq / m first, through the shared divider
                            rem_reg <= '0;
                            quo_reg <= sq_reg + x_reg[31:0] * x_reg[31:0];
                            den_reg <= 64'(m_cnt);
                            k_reg   <= 7'd64;
                            phase_reg <= 2'd0;
                            state_reg <= S_DIV1;
                        end
                        else
                        begin
                            i_reg <= i_reg + CW'(1);
                            state_reg <= S_VRD;
                        end
                    end
                end
                S_DIV1:
                begin
                    if (k_reg != 7'd0)
                    begin
                        logic [64:0] tr;
                        tr = {rem_reg, quo_reg[63]};
                        quo_reg <= {quo_reg[62:0], tr >= {1'b0, den_reg}};
                        rem_reg <= (tr >= {1'b0, den_reg}) ? 64'(tr - {1'b0, den_reg})
                                                           : tr[63:0];
                        k_reg <= k_reg - 7'd1;
                    end
                    else if (phase_reg == 2'd0)
                    begin
                        x_reg   <= quo_reg;
                        r_reg   <= '0;
                        bit_reg <= 64'd1 << 62;
                        k_reg   <= 7'd32;
                        state_reg <= S_SQRT;
                    end
                    else if (phase_reg == 2'd1)
                    begin
                        // confidence fraction done
                        cval_reg <= (quo_reg >= 64'd32768) ? 16'd0
                                    : 16'(64'd32768 - quo_reg);
                        rem_reg <= '0;
                        quo_reg <= 64'd6000000000 + 64'(key_reg >> 1);
                        den_reg <= 64'(key_reg);
                        k_reg   <= 7'd64;
                        phase_reg <= 2'd2;
                    end
                    else
                    begin
                        if (key_reg == '0 || quo_reg > 64'd65535)
                        begin
                            tempo_reg <= 16'hFFFF;
                        end
                        else
                        begin
                            tempo_reg <= quo_reg[15:0];
                        end
                        state_reg <= S_CONF;
                        phase_reg <= 2'd0;
                    end
                end
                S_SQRT:
                begin
                    if (k_reg != 7'd0)
                    begin
                        if (x_reg >= r_reg + bit_reg)
                        begin
                            x_reg <= x_reg - (r_reg + bit_reg);
                            r_reg <= (r_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            r_reg <= r_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                        k_reg <= k_reg - 7'd1;
                    end
                    else
                    begin
                        rem_reg <= '0;
                        quo_reg <= r_reg << 15;
                        den_reg <= ({32'd0, s_reg} > 64'(m_cnt) * 64'd1000)
                                   ? {32'd0, s_reg} : 64'(m_cnt) * 64'd1000;
                        k_reg <= 7'd64;
                        i_reg <= CW'(1);
                        state_reg <= S_SORT_RD;
                    end
                end
                // insertion sort on the interval scratch, one compare a step
                S_SORT_RD:
                begin
                    if (i_reg >= m_cnt)
                    begin
                        state_reg <= S_MED_RD;
                    end
                    else
                    begin
                        j_reg <= i_reg;
                        phase_reg <= 2'd0;
                        state_reg <= S_SORT_WAIT;
                    end
                end
                S_SORT_WAIT:
                begin
                    state_reg <= S_SORT_CMP;
                end
                S_SORT_CMP:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        key_reg <= ram_rdata;
                        phase_reg <= 2'd1;
                        state_reg <= (j_reg == '0) ? S_SORT_CMP : S_SORT_WAIT;
                    end
                    else if (j_reg != '0 && ram_rdata > key_reg)
                    begin
                        j_reg <= j_reg - CW'(1);
                        state_reg <= (j_reg == CW'(1)) ? S_SORT_CMP : S_SORT_WAIT;
                        phase_reg <= (j_reg == CW'(1)) ? 2'd2 : 2'd1;
                    end
                    else
                    begin
                        i_reg <= i_reg + CW'(1);
                        state_reg <= S_SORT_RD;
                    end
                end
                S_MED_RD:
                begin
                    state_reg <= S_MED_WAIT;
                end
                S_MED_WAIT:
                begin
                    state_reg <= S_TEMPO;
                end
                S_TEMPO:
                begin
                    logic [31:0] md;
                    md = ram_rdata;
                    if (md < 32'(minp_reg))
                    begin
                        md = 32'(minp_reg);
                    end
                    if (md > 32'(maxp_reg))
                    begin
                        md = 32'(maxp_reg);
                    end
                    key_reg <= md;
                    phase_reg <= 2'd1;
                    state_reg <= S_DIV1;
                end
                S_CONF:
                begin
                    if (phase_reg == 2'd2)
                    begin
                        // drop detection below 0.05: conf * 20 < 1.0
                        if ({1'b0, prod_reg[31:16], 4'd0} + {3'd0, prod_reg[31:16], 2'd0}
                            < 21'd32768)
                        begin
                            det_reg <= 1'b0;
                        end
                        conf_reg <= prod_reg[31:16];
                    end
                    else
                    begin
                        conf_reg <= 16'(({1'b0, conf_reg} + {1'b0, cval_reg}) >> 1);
                        det_reg <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!m_tvalid || m_tready)
                    begin
                        m_tvalid <= 1'b1;
                        m_tdata  <= {5'd0, det_reg, conf_reg, tempo_reg, upd_reg, beat_reg};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // memory port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = now_reg;
        ram_raddr = '0;
        case (state_reg)
            S_UPD:
            begin
                if (phase_reg == 2'd0 && $signed(excess) > $signed(thr)
                    && {2'b0, minp_reg} <= tsb_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = {1'b0, ring(head_reg, cnt_reg < CW'(HISTORY_DEPTH)
                                                      ? cnt_reg : '0)};
                end
            end
            S_IVRD, S_IVWAIT:
            begin
                ram_raddr = {1'b0, ring(head_reg, i_reg)};
            end
            S_IVGET:
            begin
                ram_raddr = {1'b0, ring(head_reg, i_reg)};
                if (i_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = (HW+1)'(HISTORY_DEPTH) + (HW+1)'(i_reg - CW'(1));
                    ram_wdata = ram_rdata - prev_reg;
                end
            end
            S_VRD, S_VWAIT, S_VACC:
            begin
                ram_raddr = (HW+1)'(HISTORY_DEPTH) + (HW+1)'(i_reg);
            end
            S_SORT_RD, S_SORT_WAIT:
            begin
                ram_raddr = (HW+1)'(HISTORY_DEPTH)
                            + (HW+1)'((phase_reg == 2'd0 && state_reg == S_SORT_RD) ? i_reg
                              : (state_reg == S_SORT_RD ? i_reg : j_reg - CW'(phase_reg != 2'd0)));
            end
            S_SORT_CMP:
            begin
                ram_raddr = (HW+1)'(HISTORY_DEPTH) + (HW+1)'(j_reg - CW'(1));
                if (phase_reg != 2'd0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = (HW+1)'(HISTORY_DEPTH) + (HW+1)'(j_reg);
                    ram_wdata = (j_reg != '0 && ram_rdata > key_reg && phase_reg == 2'd1)
                                ? ram_rdata : key_reg;
                end
            end
            S_MED_RD, S_MED_WAIT:
            begin
                ram_raddr = (HW+1)'(HISTORY_DEPTH) + (HW+1)'(m_cnt >> 1);
            end
            default: ;
        endcase
    end
endmodule

// File: hw/rtl/opte_checker.sv
// Port-level checker for the tempo estimator, bound to the top level.
// No package dependencies; sees only the top-level ports.
module opte_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a transaction while busy");
    a_conf: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[33:18] <= 16'd32768)
        else $error("confidence above one");
    // a detected tempo always comes from an estimate, which never yields zero
    a_det: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34] |-> m_tdata[17:2] != 16'd0)
        else $error("detected without estimate");
endmodule

bind onset_peak_tempo_estimator opte_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
